// File: design/rc4_stream_cipher_top_defines.svh
// Assertion helpers shared by the cipher RTL
`ifndef RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`define RC4_STREAM_CIPHER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset
`define RC4_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rc4_pkg.sv
package rc4_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int IDX_W      = 8;
    localparam int KEY_W      = 64;
    localparam int LEN_W      = 5;
    localparam int POS_W      = 4;
    localparam int CFG_IDX_W  = 2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [7:0]       byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW    = 2'd0,
        CFG_KEY_HIGH   = 2'd1,
        CFG_KEY_LENGTH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        byte_t data_byte;
        logic  rekey;
    } in_item_t;

    typedef struct packed {
        byte_t cipher_byte;
        byte_t keystream_byte;
    } out_item_t;

    // One request per cycle to the S-box store
    typedef struct packed {
        logic  re;
        idx_t  raddr;
        logic  we;
        idx_t  waddr;
        byte_t wdata;
        logic  clear;
    } mem_req_t;

endpackage

// File: design/rc4_stream_cipher_top.sv
// RC4 keystream engine.
// Input channel (in_valid/in_ready/in_item): one data byte and a rekey flag per item.
// Output channel (out_valid/out_ready/out_item): data XOR keystream, and the keystream byte.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 key bytes 0-7,
// index 1 key bytes 8-15, index 2 key length; other indices are ignored. Write only when idle.
// Each item runs through ST_RDJ, ST_SWAP and ST_FIN: read S[i], read S[j], then the two
// write-backs of the swap, the first alongside the read of S[t], all through the single
// S-box store. The result is loaded into the output register in ST_FIN; the next item is
// taken in the cycle that result is loaded. A rekey item first runs the key schedule, 256
// steps through the same states, and the input channel stays closed meanwhile.
// Reset: S-box reads as the identity permutation (per-entry valid bits), i and j are zero,
// key registers are zero and the key length is 16. No clearing pass is needed.
// A stalled receiver holds the result in the output register; the engine parks with its
// final write-back pending and takes no new item until the register frees up.
module rc4_stream_cipher_top
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data
);

    logic [KEY_W-1:0] key_low_reg;
    logic [KEY_W-1:0] key_high_reg;
    logic [LEN_W-1:0] key_length_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic      can_load;
    logic      res_load;
    out_item_t res_item;
    mem_req_t  mem_req;
    byte_t     rdata;

    assign cfg_ready = 1'b1;
    assign can_load  = ~out_valid_reg | out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= LEN_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                CFG_KEY_LENGTH: key_length_reg <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_item_reg <= res_item;
        end
    end

    rc4_ctrl #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .key_length (key_length_reg),
        .can_load   (can_load),
        .res_load   (res_load),
        .res_item   (res_item),
        .mem_req    (mem_req),
        .rdata      (rdata)
    );

    rc4_sbox_mem u_sbox (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (rdata)
    );

endmodule

// File: design/rc4_sbox_mem.sv
`include "rc4_stream_cipher_top_defines.svh"

module rc4_sbox_mem
    import rc4_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output byte_t    rdata
);

    byte_t                 sbox_ram [SBOX_DEPTH];
    logic [SBOX_DEPTH-1:0] vbits_reg;
    byte_t                 rdata_reg;
    byte_t                 fwd_data_reg;
    idx_t                  raddr_reg;
    logic                  vld_reg;
    logic                  fwd_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            sbox_ram[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg    <= sbox_ram[req.raddr];
            raddr_reg    <= req.raddr;
            fwd_data_reg <= req.wdata;
        end
    end

    // Entries not written since the last clear read as their own address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbits_reg <= '0;
            vld_reg   <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                vbits_reg <= '0;
            end
            else if (req.we)
            begin
                vbits_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                vld_reg <= vbits_reg[req.raddr] & ~req.clear;
                fwd_reg <= req.we & ~req.clear & (req.waddr == req.raddr);
            end
        end
    end

    assign rdata = fwd_reg ? fwd_data_reg : (vld_reg ? rdata_reg : byte_t'(raddr_reg));

    `RC4_ASSERT_NEXT(a_clear_empties, req.clear, vbits_reg == '0, "valid bits survive a clear")

endmodule

// File: design/rc4_ctrl.sv
`include "rc4_stream_cipher_top_defines.svh"

module rc4_ctrl
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    input  logic [KEY_W-1:0] key_low,
    input  logic [KEY_W-1:0] key_high,
    input  logic [LEN_W-1:0] key_length,
    input  logic             can_load,
    output logic             res_load,
    output out_item_t        res_item,
    output mem_req_t         mem_req,
    input  byte_t            rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RDJ,
        ST_SWAP,
        ST_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic             ks_mode_reg, ks_mode_next;
    idx_t             i_reg, i_next;
    idx_t             j_reg, j_next;
    byte_t            si_reg, si_next;
    byte_t            sj_reg, sj_next;
    idx_t             t_reg, t_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    byte_t            data_reg, data_next;

    logic [LEN_W-1:0] eff_len;
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] pos_adv;
    byte_t            key_sel;
    byte_t            ks;
    idx_t             j_sum;
    idx_t             t_sum;

    always_comb
    begin
        eff_len = key_length;
        if (eff_len == '0)
        begin
            eff_len = LEN_W'(1);
        end
        if (eff_len > LEN_W'(MAX_KEY_BYTES))
        begin
            eff_len = LEN_W'(MAX_KEY_BYTES);
        end
    end

    assign pos_inc = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign pos_adv = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];
    assign key_sel = pos_reg[POS_W-1] ? key_high[{pos_reg[2:0], 3'b000} +: 8]
                                      : key_low[{pos_reg[2:0], 3'b000} +: 8];

    // Output index may hit either swapped entry; S[i] is forwarded by the store
    assign ks = (t_reg == j_reg) ? si_reg : ((t_reg == i_reg) ? sj_reg : rdata);
    assign res_item.keystream_byte = ks;
    assign res_item.cipher_byte    = data_reg ^ ks;

    assign j_sum = j_reg + rdata + (ks_mode_reg ? key_sel : byte_t'(0));
    assign t_sum = si_reg + rdata;

    always_comb
    begin
        state_next   = state_reg;
        ks_mode_next = ks_mode_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        si_next      = si_reg;
        sj_next      = sj_reg;
        t_next       = t_reg;
        pos_next     = pos_reg;
        data_next    = data_reg;
        mem_req      = '0;
        res_load     = 1'b0;
        in_ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_RDJ:
            begin
                si_next       = rdata;
                j_next        = j_sum;
                mem_req.re    = 1'b1;
                mem_req.raddr = j_sum;
                state_next    = ST_SWAP;
            end
            ST_SWAP:
            begin
                sj_next       = rdata;
                mem_req.we    = 1'b1;
                mem_req.waddr = i_reg;
                mem_req.wdata = rdata;
                if (!ks_mode_reg)
                begin
                    t_next        = t_sum;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = t_sum;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (ks_mode_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = j_reg;
                    mem_req.wdata = si_reg;
                    pos_next      = pos_adv;
                    if (i_reg == idx_t'(SBOX_DEPTH - 1))
                    begin
                        // schedule done: set i to 1, clear j and start the pending item
                        ks_mode_next = 1'b0;
                        i_next       = idx_t'(1);
                        j_next       = '0;
                    end
                    else
                    begin
                        i_next = i_reg + idx_t'(1);
                    end
                    mem_req.re    = 1'b1;
                    mem_req.raddr = i_next;
                    state_next    = ST_RDJ;
                end
                else if (can_load)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = j_reg;
                    mem_req.wdata = si_reg;
                    res_load      = 1'b1;
                    in_ready      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (in_valid && in_ready)
        begin
            data_next  = in_item.data_byte;
            state_next = ST_RDJ;
            mem_req.re = 1'b1;
            if (in_item.rekey)
            begin
                mem_req.clear = 1'b1;
                ks_mode_next  = 1'b1;
                i_next        = '0;
                j_next        = '0;
                pos_next      = '0;
                mem_req.raddr = '0;
            end
            else
            begin
                i_next        = i_reg + idx_t'(1);
                mem_req.raddr = i_reg + idx_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ks_mode_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            si_reg      <= '0;
            sj_reg      <= '0;
            t_reg       <= '0;
            pos_reg     <= '0;
            data_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ks_mode_reg <= ks_mode_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            si_reg      <= si_next;
            sj_reg      <= sj_next;
            t_reg       <= t_next;
            pos_reg     <= pos_next;
            data_reg    <= data_next;
        end
    end

    `RC4_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == ST_RDJ, "accept did not start a step")
    `RC4_ASSERT_NEXT(a_fin_holds, (state_reg == ST_FIN) && !ks_mode_reg && !can_load, (state_reg == ST_FIN) && $stable(j_reg), "stalled result lost")
    `RC4_ASSERT_SAME(a_sched_busy, ks_mode_reg, !in_ready && !res_load, "item taken during key schedule")

endmodule
